// ----- design/rbsi_pkg.sv -----
// Shared types and constants for the ray/box slab intersection block.
`default_nettype none
package rbsi_pkg;
    localparam int AXES         = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int DIST_BITS    = 31;
    localparam int OUT_BITS     = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Z = 3'd5;

    // Per-axis status that travels from an axis lane to the merge stage
    typedef struct packed {
        logic unb;   // zero direction: no bound on this axis
        logic miss;  // this axis alone rules the ray out
    } axis_flag_t;
endpackage
`default_nettype wire

// ----- design/rbsi_div.sv -----
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
`default_nettype none
module rbsi_div #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [COORD_BITS-1:0] bnd,
    input  wire logic signed [COORD_BITS-1:0] org,
    input  wire logic signed [COORD_BITS-1:0] dir,
    output logic signed [COORD_BITS-1:0]      quot
);
    localparam int W  = COORD_BITS;
    localparam int DW = W + 1;
    localparam int NW = W + 1 + FRAC_BITS;
    localparam int RW = NW + W;
    localparam logic [W-1:0] HALF  = W'(1) << (W - 1);
    localparam logic [W-1:0] Q_MAX = HALF - W'(1);

    logic signed [DW-1:0] diff;
    logic [DW-1:0]        diff_mag;
    logic [W-1:0]         dir_mag;
    logic [RW-1:0]        num;
    logic                 neg;
    logic                 ovf;

    logic [RW-1:0] rem_reg [0:W];
    logic [W-1:0]  dv_reg  [0:W];
    logic [W-1:0]  q_reg   [0:W];
    logic          neg_reg [0:W];
    logic          ovf_reg [0:W];

    always_comb begin
        diff     = DW'(bnd) - DW'(org);
        diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
        dir_mag  = dir[W-1] ? W'(-dir) : W'(dir);
        num      = RW'({diff_mag, {FRAC_BITS{1'b0}}});
        neg      = diff[DW-1] ^ dir[W-1];
        ovf      = num >= (RW'(dir_mag) << W);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            dv_reg[0]  <= dir_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf;
        end
    end

    for (genvar s = 1; s <= W; s++) begin : g_stage
        localparam int BIT = W - s;
        logic [RW:0] trial;
        logic        ge;
        assign trial = {1'b0, rem_reg[s-1]} - ({1'b0, RW'(dv_reg[s-1])} << BIT);
        assign ge    = !trial[RW];
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= ge ? trial[RW-1:0] : rem_reg[s-1];
                q_reg[s]   <= q_reg[s-1] | (W'(ge) << BIT);
                dv_reg[s]  <= dv_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    // Truncate toward zero, then clamp to the signed coordinate range
    always_comb begin
        if (ovf_reg[W]) begin
            quot = neg_reg[W] ? signed'(HALF) : signed'(Q_MAX);
        end else if (neg_reg[W]) begin
            quot = (q_reg[W] > HALF) ? signed'(HALF) : signed'(W'(-q_reg[W]));
        end else begin
            quot = (q_reg[W] > Q_MAX) ? signed'(Q_MAX) : signed'(q_reg[W]);
        end
    end
endmodule
`default_nettype wire

// ----- design/rbsi_axis.sv -----
// One axis lane: both slab bounds, zero-direction test, near/far ordering.
`default_nettype none
module rbsi_axis #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [COORD_BITS-1:0] lo,
    input  wire logic signed [COORD_BITS-1:0] hi,
    input  wire logic signed [COORD_BITS-1:0] org,
    input  wire logic signed [COORD_BITS-1:0] dir,
    output logic signed [COORD_BITS-1:0]      near_reg,
    output logic signed [COORD_BITS-1:0]      far_reg,
    output rbsi_pkg::axis_flag_t              flag_reg
);
    localparam int W = COORD_BITS;

    logic signed [W-1:0] qa;
    logic signed [W-1:0] qb;
    logic                zero_reg [0:W];
    logic                inr_reg  [0:W];

    rbsi_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_lo (
        .aclk(aclk), .en(en), .bnd(lo), .org(org), .dir(dir), .quot(qa)
    );
    rbsi_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_hi (
        .aclk(aclk), .en(en), .bnd(hi), .org(org), .dir(dir), .quot(qb)
    );

    // Side flags follow the divider stages
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (dir == '0);
            inr_reg[0]  <= (org >= lo) && (org <= hi);
            for (int s = 1; s <= W; s++) begin
                zero_reg[s] <= zero_reg[s-1];
                inr_reg[s]  <= inr_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            near_reg      <= (qa < qb) ? qa : qb;
            far_reg       <= (qa < qb) ? qb : qa;
            flag_reg.unb  <= zero_reg[W];
            flag_reg.miss <= zero_reg[W] && !inr_reg[W];
        end
    end
endmodule
`default_nettype wire

// ----- design/rbsi_merge.sv -----
// Merge of the three axis lanes: entry/exit reduction, then hit decision.
`default_nettype none
module rbsi_merge #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [COORD_BITS-1:0] near_in [rbsi_pkg::AXES],
    input  wire logic signed [COORD_BITS-1:0] far_in  [rbsi_pkg::AXES],
    input  wire rbsi_pkg::axis_flag_t         flag_in [rbsi_pkg::AXES],
    output logic                              hit_reg,
    output logic [rbsi_pkg::DIST_BITS-1:0]    dist_reg
);
    localparam int W = COORD_BITS;
    localparam logic signed [W-1:0] Q_MAX = signed'((W'(1) << (W - 1)) - W'(1));

    logic signed [W-1:0] entry;
    logic signed [W-1:0] exitb;
    logic                ent_inf;
    logic                ext_inf;
    logic                miss;

    logic signed [W-1:0] entry_reg;
    logic signed [W-1:0] exit_reg;
    logic                ent_inf_reg;
    logic                ext_inf_reg;
    logic                miss_reg;

    logic                hit_next;
    logic signed [W-1:0] t;
    logic [63:0]         t_ext;

    always_comb begin
        entry   = '0;
        exitb   = '0;
        ent_inf = 1'b1;
        ext_inf = 1'b1;
        miss    = 1'b0;
        for (int k = 0; k < rbsi_pkg::AXES; k++) begin
            miss = miss | flag_in[k].miss;
            if (!flag_in[k].unb) begin
                if (ent_inf || near_in[k] > entry) begin
                    entry = near_in[k];
                end
                if (ext_inf || far_in[k] < exitb) begin
                    exitb = far_in[k];
                end
                ent_inf = 1'b0;
                ext_inf = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            entry_reg   <= entry;
            exit_reg    <= exitb;
            ent_inf_reg <= ent_inf;
            ext_inf_reg <= ext_inf;
            miss_reg    <= miss;
        end
    end

    always_comb begin
        hit_next = !miss_reg;
        if (!ext_inf_reg && exit_reg < 0) begin
            hit_next = 1'b0;
        end
        if (!ent_inf_reg && !ext_inf_reg && entry_reg > exit_reg) begin
            hit_next = 1'b0;
        end
        // Origin inside the box: report the exit
        if (ent_inf_reg || entry_reg < 0) begin
            t = ext_inf_reg ? Q_MAX : exit_reg;
        end else begin
            t = entry_reg;
        end
        t_ext = 64'(unsigned'(t));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg  <= hit_next;
            dist_reg <= hit_next ? t_ext[rbsi_pkg::DIST_BITS-1:0] : '0;
        end
    end
endmodule
`default_nettype wire

// ----- design/ray_box_slab_intersect.sv -----
// Top level: ray against axis-aligned box, slab method, three axis lanes.
//
//  channel | direction | handshake             | payload
//  s_      | in        | s_tvalid / s_tready   | s_tdata: ray origin and direction
//  m_      | out       | m_tvalid / m_tready   | m_tdata: hit, distance
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data: box corners
//
// One ray per cycle while the output is not stalled; the pipeline is made of the
// bit-per-stage dividers (two per axis) plus lane, merge and output registers.
// Reset (aresetn low, synchronous) empties the pipeline and zeroes the box.
// The whole pipeline holds while a result sits in the output register unread.
// Configuration writes are taken every cycle.
`default_nettype none
module ray_box_slab_intersect #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  wire logic [6*COORD_BITS-1:0]              s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // hit, distance
    output logic [rbsi_pkg::OUT_BITS-1:0]             m_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rbsi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [COORD_BITS-1:0]                cfg_data
);
    localparam int W   = COORD_BITS;
    localparam int LAT = W + 4;

    logic                 en;
    logic [LAT-1:0]       vld_reg;
    logic signed [W-1:0]  box_min_reg [rbsi_pkg::AXES];
    logic signed [W-1:0]  box_max_reg [rbsi_pkg::AXES];
    logic signed [W-1:0]  near_w [rbsi_pkg::AXES];
    logic signed [W-1:0]  far_w  [rbsi_pkg::AXES];
    rbsi_pkg::axis_flag_t flag_w [rbsi_pkg::AXES];
    logic                 hit;
    logic [rbsi_pkg::DIST_BITS-1:0] dist_w;

    // Advance everything unless the output beat is stuck
    assign en        = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[LAT-1];
    assign m_tdata   = {dist_w, hit};
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < rbsi_pkg::AXES; k++) begin
                box_min_reg[k] <= '0;
                box_max_reg[k] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rbsi_pkg::REG_MIN_X: box_min_reg[0] <= cfg_data;
                rbsi_pkg::REG_MIN_Y: box_min_reg[1] <= cfg_data;
                rbsi_pkg::REG_MIN_Z: box_min_reg[2] <= cfg_data;
                rbsi_pkg::REG_MAX_X: box_max_reg[0] <= cfg_data;
                rbsi_pkg::REG_MAX_Y: box_max_reg[1] <= cfg_data;
                rbsi_pkg::REG_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < rbsi_pkg::AXES; k++) begin : g_lane
        rbsi_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis (
            .aclk     (aclk),
            .en       (en),
            .lo       (box_min_reg[k]),
            .hi       (box_max_reg[k]),
            .org      (signed'(s_tdata[k*W +: W])),
            .dir      (signed'(s_tdata[(k+rbsi_pkg::AXES)*W +: W])),
            .near_reg (near_w[k]),
            .far_reg  (far_w[k]),
            .flag_reg (flag_w[k])
        );
    end

    rbsi_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .aclk     (aclk),
        .en       (en),
        .near_in  (near_w),
        .far_in   (far_w),
        .flag_in  (flag_w),
        .hit_reg  (hit),
        .dist_reg (dist_w)
    );
endmodule
`default_nettype wire

// ----- design/rbsi_chk.sv -----
// Port-level checker for the intersect block, bound to the top level.
`default_nettype none
module rbsi_chk (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [rbsi_pkg::OUT_BITS-1:0]    m_tdata
);
    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A miss carries a zero distance
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[rbsi_pkg::OUT_BITS-1:1] == '0)
        else $error("miss with nonzero distance");

    // Input stalls while the output beat is stuck
    a_back_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
endmodule

bind ray_box_slab_intersect rbsi_chk u_rbsi_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
